/* src/rlm_pkg.sv */
`default_nettype none

package rlm_pkg;

  // field widths
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned SUM_WIDTH    = 48;

  // derived datapath widths
  localparam int unsigned DIFF_WIDTH    = SAMPLE_WIDTH + 1;
  localparam int unsigned SQ_WIDTH      = 2 * SAMPLE_WIDTH;
  localparam int unsigned ROOT_WIDTH    = SUM_WIDTH / 2;
  localparam int unsigned SREM_WIDTH    = ROOT_WIDTH + 2;
  localparam int unsigned DREM_WIDTH    = COUNT_WIDTH + 1;
  localparam int unsigned STEP_WIDTH    = $clog2(SUM_WIDTH);

  // window record queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = '1;

  // one closed window, handed from accumulator to divide/root unit
  typedef struct packed {
    logic [SUM_WIDTH-1:0]   sum;
    logic [COUNT_WIDTH-1:0] count;
    logic                   ovf;
  } rlm_window_t;

endpackage

`default_nettype wire

/* src/rlm_if.sv */
`default_nettype none

// sample stream
interface rlm_sample_if import rlm_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// result stream
interface rlm_result_if import rlm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] rms_value;
  logic [COUNT_WIDTH-1:0]  window_count;
  logic                    overflow;

  modport source (output valid, output rms_value, output window_count, output overflow,
                  input ready);
  modport sink (input valid, input rms_value, input window_count, input overflow,
                output ready);
endinterface

// dc offset register write
interface rlm_cfg_if import rlm_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rlm_front.sv */
`default_nettype none

module rlm_front import rlm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlm_sample_if.sink  sample_i,
  rlm_cfg_if.sink     cfg_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output rlm_window_t push_data_o
);

  logic signed [SAMPLE_WIDTH-1:0] dc_offset_q;

  logic signed [DIFF_WIDTH-1:0] diff;
  logic [DIFF_WIDTH-1:0]        abs_full;
  logic [SAMPLE_WIDTH-1:0]      mag;
  logic [SQ_WIDTH-1:0]          sq_d, sq_q;

  logic s1_valid_q, s1_last_q, s1_go, in_ready, in_accept;

  logic [SUM_WIDTH-1:0]   sum_q, acc_sum;
  logic [COUNT_WIDTH-1:0] count_q, acc_count;
  logic                   ovf_q, acc_ovf;
  logic [SUM_WIDTH:0]     sum_ext;

  // config register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_offset_q <= '0;
    end else if (cfg_i.valid) begin
      dc_offset_q <= cfg_i.data;
    end
  end

  // offset removal and square
  always_comb begin
    diff     = DIFF_WIDTH'(sample_i.sample) - DIFF_WIDTH'(dc_offset_q);
    abs_full = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
    mag      = abs_full[SAMPLE_WIDTH-1:0];
    sq_d     = SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
  end

  // square stage handshake: a last item waits until the queue has room
  assign s1_go       = s1_valid_q && (!s1_last_q || push_ready_i);
  assign in_ready    = !s1_valid_q || s1_go;
  assign in_accept   = sample_i.valid && in_ready;
  assign sample_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sq_q      <= sq_d;
      s1_last_q <= sample_i.last;
    end
  end

  // accumulate with count and sum saturation
  assign sum_ext = {1'b0, sum_q} + (SUM_WIDTH + 1)'(sq_q);

  always_comb begin
    acc_sum   = sum_q;
    acc_count = count_q;
    acc_ovf   = ovf_q;
    if (count_q == COUNT_MAX) begin
      acc_ovf = 1'b1;
    end else begin
      if (sum_ext[SUM_WIDTH]) begin
        acc_sum = SUM_MAX;
        acc_ovf = 1'b1;
      end else begin
        acc_sum = sum_ext[SUM_WIDTH-1:0];
      end
      acc_count = count_q + 1'b1;
    end
  end

  assign push_valid_o = s1_valid_q && s1_last_q;
  assign push_data_o  = '{sum: acc_sum, count: acc_count, ovf: acc_ovf};

  // window state, cleared when the window closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= acc_sum;
        count_q <= acc_count;
        ovf_q   <= acc_ovf;
      end
    end
  end

`ifndef ASSERT_OFF
  // a full count sets the flag on the next sample that does not close the window
  a_count_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !s1_last_q && count_q == COUNT_MAX |=> ovf_q && count_q == COUNT_MAX)
    else $error("count full did not set overflow");

  // closing a window clears all window state
  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> count_q == '0 && sum_q == '0 && !ovf_q)
    else $error("window state not cleared");

  // input stalls only while a closed window waits for queue room
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> s1_valid_q && s1_last_q && !push_ready_i)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

/* src/rlm_queue.sv */
`default_nettype none

module rlm_queue import rlm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  rlm_window_t push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output rlm_window_t pop_data_o
);

  rlm_window_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_WIDTH:0]     fill_q;
  logic                    push, pop;

  assign push_ready_o = fill_q != (QPTR_WIDTH + 1)'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/rlm_back.sv */
`default_nettype none

module rlm_back import rlm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  rlm_window_t  pop_data_i,
  rlm_result_if.source result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_HOLD
  } state_e;

  state_e                 state_q;
  logic [STEP_WIDTH-1:0]  step_q;
  logic [SUM_WIDTH-1:0]   work_q;
  logic [DREM_WIDTH-1:0]  rem_q;
  logic [COUNT_WIDTH-1:0] divisor_q;
  logic                   ovf_q;
  logic [ROOT_WIDTH-1:0]  root_q;
  logic [SREM_WIDTH-1:0]  srem_q;

  logic                    res_valid_q;
  logic [SAMPLE_WIDTH-1:0] res_rms_q;
  logic [COUNT_WIDTH-1:0]  res_count_q;
  logic                    res_ovf_q;

  logic [DREM_WIDTH-1:0]   rem_shift;
  logic [DREM_WIDTH:0]     div_diff;
  logic                    div_ge;
  logic [SUM_WIDTH-1:0]    quot_next;
  logic [SREM_WIDTH+1:0]   srem_shift;
  logic [SREM_WIDTH+2:0]   sqrt_diff;
  logic                    sqrt_ge;
  logic                    out_free;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_shift = {rem_q[COUNT_WIDTH-1:0], work_q[SUM_WIDTH-1]};
    div_diff  = {1'b0, rem_shift} - (DREM_WIDTH + 1)'(divisor_q);
    div_ge    = !div_diff[DREM_WIDTH];
    quot_next = {work_q[SUM_WIDTH-2:0], div_ge};
  end

  // digit-by-digit square root, two radicand bits a cycle
  always_comb begin
    srem_shift = {srem_q, work_q[SUM_WIDTH-1 -: 2]};
    sqrt_diff  = {1'b0, srem_shift} - (SREM_WIDTH + 3)'({root_q, 2'b01});
    sqrt_ge    = !sqrt_diff[SREM_WIDTH+2];
  end

  assign out_free    = !res_valid_q || result_o.ready;
  assign pop_ready_o = state_q == ST_IDLE;

  assign result_o.valid        = res_valid_q;
  assign result_o.rms_value    = res_rms_q;
  assign result_o.window_count = res_count_q;
  assign result_o.overflow     = res_ovf_q;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_HOLD && out_free) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            step_q  <= STEP_WIDTH'(SUM_WIDTH - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            step_q  <= STEP_WIDTH'(ROOT_WIDTH - 1);
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_SQRT: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          work_q    <= pop_data_i.sum;
          rem_q     <= '0;
          divisor_q <= pop_data_i.count;
          ovf_q     <= pop_data_i.ovf;
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? div_diff[DREM_WIDTH-1:0] : rem_shift;
        if (step_q == '0) begin
          // zero count reads as a zero mean
          work_q <= (divisor_q == '0) ? '0 : quot_next;
          root_q <= '0;
          srem_q <= '0;
        end else begin
          work_q <= quot_next;
        end
      end
      ST_SQRT: begin
        work_q <= {work_q[SUM_WIDTH-3:0], 2'b00};
        root_q <= {root_q[ROOT_WIDTH-2:0], sqrt_ge};
        srem_q <= sqrt_ge ? sqrt_diff[SREM_WIDTH-1:0] : srem_shift[SREM_WIDTH-1:0];
      end
      ST_HOLD: begin
        if (out_free) begin
          res_rms_q   <= root_q[SAMPLE_WIDTH-1:0];
          res_count_q <= divisor_q;
          res_ovf_q   <= ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rms_level_meter.sv */
`default_nettype none

// channel   dir  fields                               accepted when
// sample_i  in   sample[15:0] signed, last            valid && ready
// result_o  out  rms_value, window_count, overflow    valid && ready
// cfg_i     in   data[15:0] signed (dc_offset)        valid && ready (ready tied high)
//
// samples are taken one per cycle: a square stage, then the accumulator
// a closed window passes through a two-entry queue to a shared divide/root sequencer
// each window's result passes the sequencer's divide, root and hold states in turn
// sampling stalls only when a window closes while the queue holds two windows
// rst_ni clears window state, queue, sequencer and dc_offset (to zero)

module rms_level_meter import rlm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rlm_sample_if.sink   sample_i,
  rlm_result_if.source result_o,
  rlm_cfg_if.sink      cfg_i
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  rlm_window_t push_data, pop_data;

  // accumulator front
  rlm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // window record queue
  rlm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // divide and root back end
  rlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

/* tb/tb_rms_level_meter.sv */
`timescale 1ns / 1ps

module tb_rms_level_meter;
  import rlm_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_ROWS      = 25;

  // one rms result as seen on the result channel
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] rms_value;
    logic [COUNT_WIDTH-1:0]  window_count;
    logic                    overflow;
  } meter_result_t;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_CFG} row_kind_e;

  // directed row: a sample item or an offset write, with an optional typed-in result
  typedef struct packed {
    row_kind_e               kind;
    logic [SAMPLE_WIDTH-1:0] value;
    logic                    closes;
    logic                    typed;
    meter_result_t           want;
  } row_t;

  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // offset at reset value zero
    '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, '{16'd0, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 1'b1, '{16'd32767, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, '{16'd32768, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'hffff, 1'b1, 1'b1, '{16'd1, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'hffff, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h0003, 1'b1, 1'b1, '{16'd1, 16'd3, 1'b0}},
    '{ROW_SAMPLE, 16'h7fff, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h7fff, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'haaaa, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h00ff, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'hff00, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 16'h0064, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'hff9c, 1'b1, 1'b1, '{16'd100, 16'd2, 1'b0}},
    // largest positive offset
    '{ROW_CFG,    16'h7fff, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, '{16'd65535, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 1'b1, '{16'd0, 16'd1, 1'b0}},
    // largest negative offset
    '{ROW_CFG,    16'h8000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 1'b1, '{16'd65535, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, '{16'd0, 16'd1, 1'b0}},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, '{16'd32768, 16'd1, 1'b0}},
    '{ROW_CFG,    16'h0000, 1'b0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rlm_sample_if sample_if ();
  rlm_result_if result_if ();
  rlm_cfg_if    cfg_if ();

  rms_level_meter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // window state and offset as the meter should hold them
  longint unsigned                acc_sum;
  int unsigned                    acc_count;
  bit                             acc_ovf;
  logic signed [SAMPLE_WIDTH-1:0] dc_level;

  meter_result_t pending_levels[$];

  bit idle_on;
  int error_count      = 0;
  int samples_sent;
  int windows_checked  = 0;
  int overflow_windows = 0;
  int cfg_writes;
  int stall_cycles     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // accumulate one sample; on a closing sample produce the rms result and clear
  function automatic bit predict_level(input logic [SAMPLE_WIDTH-1:0] raw, input logic closes,
                                       output meter_result_t res);
    longint          delta;
    longint unsigned sq;
    longint unsigned total;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned trial;
    res = '0;
    delta = longint'($signed(raw)) - longint'(dc_level);
    if (delta < 0) delta = -delta;
    sq = delta * delta;
    if (acc_count >= COUNT_MAX) begin
      acc_ovf = 1'b1;
    end else begin
      total = acc_sum + sq;
      if (total > SUM_MAX) begin
        total = SUM_MAX;
        acc_ovf = 1'b1;
      end
      acc_sum = total;
      acc_count++;
    end
    if (!closes) return 1'b0;
    mean = (acc_count != 0) ? acc_sum / acc_count : 0;
    // floor square root, one result bit at a time from the top
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    res.rms_value    = root[SAMPLE_WIDTH-1:0];
    res.window_count = acc_count[COUNT_WIDTH-1:0];
    res.overflow     = acc_ovf;
    acc_sum   = 0;
    acc_count = 0;
    acc_ovf   = 1'b0;
    return 1'b1;
  endfunction

  // send one sample item, with an optional idle burst in front
  task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] raw, input logic closes,
                             input logic typed, input meter_result_t want);
    int            gap;
    meter_result_t predicted;
    gap = 0;
    if (idle_on && $urandom_range(99) < 15) gap = $urandom_range(5, 1);
    @(negedge clk_i);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= raw;
    sample_if.last   <= closes;
    do @(posedge clk_i); while (!sample_if.ready);
    samples_sent++;
    if (predict_level(raw, closes, predicted)) begin
      pending_levels.push_back(typed ? want : predicted);
    end
  endtask

  // stop sending, wait for every result, then let the divide/root stage go quiet
  task automatic drain_meter();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // write the dc offset register while the meter is idle
  task automatic set_dc_level(input logic [SAMPLE_WIDTH-1:0] level);
    drain_meter();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= level;
    do @(posedge clk_i); while (!cfg_if.ready);
    dc_level = level;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // random sample value: extremes, values close to the offset, or anything
  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    int mode;
    mode = $urandom_range(99);
    if (mode < 8) return 16'h8000;
    if (mode < 16) return 16'h7fff;
    if (mode < 30) return dc_level + SAMPLE_WIDTH'($urandom_range(16)) - SAMPLE_WIDTH'(8);
    return SAMPLE_WIDTH'($urandom());
  endfunction

  // whole windows of random length until enough samples have gone out
  task automatic run_windows(input int n_items);
    int sent;
    int len;
    int mode;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(99);
      if (mode < 70) len = $urandom_range(8, 1);
      else if (mode < 95) len = $urandom_range(64, 9);
      else len = $urandom_range(300, 65);
      for (int i = 0; i < len; i++) begin
        push_sample(pick_sample(), i == len - 1, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result sink with random not-ready bursts
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && idle_on && $urandom_range(99) < 15) hold_left = $urandom_range(5, 1);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // compare each result item with the oldest expected one
  always @(posedge clk_i) begin : check_results
    meter_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_levels.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result rms=%0d count=%0d ovf=%0d", $time,
                 result_if.rms_value, result_if.window_count, result_if.overflow);
      end else begin
        want = pending_levels.pop_front();
        windows_checked++;
        if (result_if.overflow) overflow_windows++;
        if (result_if.rms_value !== want.rms_value) begin
          error_count++;
          $display("%0t: rms_value mismatch expected %0d actual %0d", $time,
                   want.rms_value, result_if.rms_value);
        end
        if (result_if.window_count !== want.window_count) begin
          error_count++;
          $display("%0t: window_count mismatch expected %0d actual %0d", $time,
                   want.window_count, result_if.window_count);
        end
        if (result_if.overflow !== want.overflow) begin
          error_count++;
          $display("%0t: overflow mismatch expected %0d actual %0d", $time,
                   want.overflow, result_if.overflow);
        end
      end
    end
  end

  // watchdog on cycles where no channel moves an item
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, pending_levels.size());
        $display("rms_level_meter test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    sample_if.last   = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    acc_sum          = 0;
    acc_count        = 0;
    acc_ovf          = 1'b0;
    dc_level         = '0;
    idle_on          = 1'b1;
    samples_sent     = 0;
    cfg_writes       = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        set_dc_level(DIRECTED_ROWS[r].value);
      end else begin
        push_sample(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].closes,
                    DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    // random windows under several offsets, idling on and off
    set_dc_level(SAMPLE_WIDTH'($urandom()));
    run_windows(230);
    set_dc_level(16'h8000);
    idle_on = 1'b0;
    run_windows(230);
    idle_on = 1'b1;
    set_dc_level(16'h7fff);
    run_windows(230);
    set_dc_level(16'h0000);
    run_windows(230);
    set_dc_level(SAMPLE_WIDTH'($urandom_range(64)) - SAMPLE_WIDTH'(32));
    run_windows(230);
    // last stretch at full rate on both sides
    set_dc_level(SAMPLE_WIDTH'($urandom()));
    idle_on = 1'b0;
    run_windows(250);

    drain_meter();
    $display("sent %0d samples and %0d offset writes, checked %0d windows (%0d with overflow)",
             samples_sent, cfg_writes, windows_checked, overflow_windows);
    $display("errors found: %0d", error_count);
    if (error_count == 0) begin
      $display("rms_level_meter test passed");
    end else begin
      $display("rms_level_meter test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rlm_pkg.sv
src/rlm_if.sv
src/rlm_front.sv
src/rlm_queue.sv
src/rlm_back.sv
src/rms_level_meter.sv
tb/tb_rms_level_meter.sv
